// ----- sv/mme_pkg.sv -----
// ----------------------------------------------------------------------------
// Matrix multiply engine package
// Shared types, codes and constants of the matrix multiply engine.
// ----------------------------------------------------------------------------
package mme_pkg;

    localparam int MAX_DIM_DEF   = 8;
    localparam int FRAC_BITS_DEF = 16;

    localparam int IDX_W   = 3;
    localparam int DIM_W   = 4;
    localparam int DATA_W  = 32;
    localparam int PROD_W  = 64;
    localparam int SUM_W   = 67;
    localparam int OP_W    = 2;
    localparam int CIDX_W  = 2;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [OP_W-1:0] OP_WRITE_A = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE_B = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

    localparam logic [CIDX_W-1:0] REG_A_ROWS = 2'd0;
    localparam logic [CIDX_W-1:0] REG_A_COLS = 2'd1;
    localparam logic [CIDX_W-1:0] REG_B_ROWS = 2'd2;
    localparam logic [CIDX_W-1:0] REG_B_COLS = 2'd3;

    typedef enum logic [1:0] {
        KIND_WR_A,
        KIND_WR_B,
        KIND_CALC
    } t_kind;

    typedef struct packed {
        t_kind                    kind;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [DATA_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic [DIM_W-1:0] ar;
        logic [DIM_W-1:0] ac;
        logic [DIM_W-1:0] bc;
        logic             mismatch;
    } t_dims;

    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             first;
        logic             last_k;
        logic             last;
        logic             err;
    } t_tag;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_CALC = 2'b10
    } t_state;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] raw,
                                                 input logic [DIM_W-1:0] cap);
        logic [DIM_W-1:0] v;
        v = raw;
        if (v == '0) begin
            v = DIM_W'(1);
        end
        if (v > cap) begin
            v = cap;
        end
        return v;
    endfunction

endpackage

// ----- sv/mme_front.sv -----
// ----------------------------------------------------------------------------
// Matrix multiply engine front end
// Accepts input words, drops those that do nothing and queues the rest.
// ----------------------------------------------------------------------------
module mme_front
    import mme_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [OP_W-1:0]          i_operation,
    input  logic [IDX_W-1:0]         i_elem_row,
    input  logic [IDX_W-1:0]         i_elem_col,
    input  logic signed [DATA_W-1:0] i_elem_value,
    input  logic                     i_fifo_full,
    output logic                     o_push,
    output t_cmd                     o_cmd
);

    logic w_in_grid;
    logic w_keep;
    t_kind w_kind;
    logic r_seen;

    assign w_in_grid = (int'(i_elem_row) < MAX_DIM) && (int'(i_elem_col) < MAX_DIM);

    always_comb begin
        w_keep = 1'b0;
        w_kind = KIND_CALC;
        case (i_operation)
            OP_WRITE_A: begin
                w_keep = w_in_grid;
                w_kind = KIND_WR_A;
            end
            OP_WRITE_B: begin
                w_keep = w_in_grid;
                w_kind = KIND_WR_B;
            end
            OP_COMPUTE: begin
                w_keep = 1'b1;
                w_kind = KIND_CALC;
            end
            default: begin
                w_keep = 1'b0;
                w_kind = KIND_CALC;
            end
        endcase
    end

    // The input is held off in the first cycle after reset; after that the stall
    // follows the fill level of the queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else begin
            r_seen <= 1'b1;
        end
    end

    assign o_in_stall  = i_fifo_full || !r_seen;
    assign o_push      = i_in_valid && !o_in_stall && w_keep;
    assign o_cmd.kind  = w_kind;
    assign o_cmd.row   = i_elem_row;
    assign o_cmd.col   = i_elem_col;
    assign o_cmd.value = i_elem_value;

endmodule

// ----- sv/mme_fifo.sv -----
// ----------------------------------------------------------------------------
// Matrix multiply engine command queue
// Short first-in first-out queue between the front end and the compute back end.
// ----------------------------------------------------------------------------
module mme_fifo
    import mme_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_full,
    output logic o_empty
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_slot [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_slot[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ----- sv/mme_back.sv -----
// ----------------------------------------------------------------------------
// Matrix multiply engine back end
// Holds both matrices, walks the multiply-accumulate loop and drives results.
// ----------------------------------------------------------------------------
module mme_back
    import mme_pkg::*;
#(
    parameter int MAX_DIM   = MAX_DIM_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dims                    i_dims,
    input  t_cmd                     i_cmd,
    input  logic                     i_empty,
    output logic                     o_pop,
    input  logic                     i_out_stall,
    output logic                     o_out_valid,
    output logic [IDX_W-1:0]         o_out_row,
    output logic [IDX_W-1:0]         o_out_col,
    output logic signed [DATA_W-1:0] o_product_value,
    output logic                     o_saturated,
    output logic                     o_size_error,
    output logic                     o_last
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);

    function automatic logic [AW-1:0] f_addr(input logic [IDX_W-1:0] row,
                                             input logic [IDX_W-1:0] col);
        return AW'(int'(row) * MAX_DIM + int'(col));
    endfunction

    logic signed [DATA_W-1:0] r_mem_a [DEPTH];
    logic signed [DATA_W-1:0] r_mem_b [DEPTH];

    t_state           r_state;
    t_state           n_state;
    logic [IDX_W-1:0] r_i;
    logic [IDX_W-1:0] r_j;
    logic [IDX_W-1:0] r_k;
    logic [IDX_W-1:0] n_i;
    logic [IDX_W-1:0] n_j;
    logic [IDX_W-1:0] n_k;
    logic             r_err;
    logic             n_err;

    logic             w_pop;
    logic             w_wr_a;
    logic             w_wr_b;
    logic [AW-1:0]    w_wr_addr;
    logic [AW-1:0]    w_addr_a;
    logic [AW-1:0]    w_addr_b;
    logic             w_adv;
    logic             w_out_load;
    logic             w_j_last;
    t_tag             w_tag;

    logic                     r1_vld;
    t_tag                     r1_tag;
    logic signed [DATA_W-1:0] r_a_rd;
    logic signed [DATA_W-1:0] r_b_rd;

    logic                     r2_vld;
    t_tag                     r2_tag;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] w_mul;

    logic signed [SUM_W-1:0]  r_acc;
    logic signed [SUM_W-1:0]  w_prod_ext;
    logic signed [SUM_W-1:0]  w_acc_next;
    logic                     r_sum_vld;
    t_tag                     r_sum_tag;
    logic signed [SUM_W-1:0]  r_sum;

    logic signed [SUM_W-1:0]  w_shift;
    logic [SUM_W-32:0]        w_hi;
    logic                     w_fits;
    logic signed [DATA_W-1:0] w_clip;

    logic                     r_out_vld;

    assign w_pop     = (r_state == ST_IDLE) && !i_empty;
    assign w_wr_a    = w_pop && (i_cmd.kind == KIND_WR_A);
    assign w_wr_b    = w_pop && (i_cmd.kind == KIND_WR_B);
    assign w_wr_addr = f_addr(i_cmd.row, i_cmd.col);
    assign o_pop     = w_pop;

    assign w_out_load = r_sum_vld && (!r_out_vld || !i_out_stall);
    assign w_adv      = !r_sum_vld || w_out_load;

    assign w_j_last     = ({1'b0, r_j} == i_dims.bc - DIM_W'(1));
    assign w_tag.row    = r_i;
    assign w_tag.col    = r_j;
    assign w_tag.first  = (r_k == '0);
    assign w_tag.last_k = r_err || ({1'b0, r_k} == i_dims.ac - DIM_W'(1));
    assign w_tag.last   = r_err || (w_tag.last_k && w_j_last
                                    && ({1'b0, r_i} == i_dims.ar - DIM_W'(1)));
    assign w_tag.err    = r_err;

    assign w_addr_a = f_addr(r_i, r_k);
    assign w_addr_b = f_addr(r_k, r_j);

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_err   = r_err;
        case (r_state)
            ST_IDLE: begin
                if (w_pop && (i_cmd.kind == KIND_CALC)) begin
                    n_state = ST_CALC;
                    n_i     = '0;
                    n_j     = '0;
                    n_k     = '0;
                    n_err   = i_dims.mismatch;
                end
            end
            ST_CALC: begin
                if (w_adv) begin
                    if (w_tag.last) begin
                        n_state = ST_IDLE;
                    end else if (w_tag.last_k) begin
                        n_k = '0;
                        if (w_j_last) begin
                            n_j = '0;
                            n_i = r_i + IDX_W'(1);
                        end else begin
                            n_j = r_j + IDX_W'(1);
                        end
                    end else begin
                        n_k = r_k + IDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_err   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            r_err   <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_a) begin
            r_mem_a[w_wr_addr] <= i_cmd.value;
        end
        if (w_wr_b) begin
            r_mem_b[w_wr_addr] <= i_cmd.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_rd <= r_mem_a[w_addr_a];
            r_b_rd <= r_mem_b[w_addr_b];
        end
    end

    assign w_mul      = r_a_rd * r_b_rd;
    assign w_prod_ext = {{(SUM_W - PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign w_acc_next = r2_tag.first ? w_prod_ext : r_acc + w_prod_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r_sum_vld <= 1'b0;
        end else begin
            if (w_adv) begin
                r1_vld <= (r_state == ST_CALC);
                r2_vld <= r1_vld;
            end
            if (w_out_load) begin
                r_sum_vld <= 1'b0;
            end
            if (w_adv && r2_vld && r2_tag.last_k) begin
                r_sum_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_tag <= w_tag;
            r2_tag <= r1_tag;
            r_prod <= w_mul;
            if (r2_vld) begin
                r_acc <= w_acc_next;
            end
            if (r2_vld && r2_tag.last_k) begin
                r_sum     <= r2_tag.err ? '0 : w_acc_next;
                r_sum_tag <= r2_tag;
            end
        end
    end

    // The exact sum is floored by the arithmetic shift, then clipped to 32 bits.
    assign w_shift = r_sum >>> FRAC_BITS;
    assign w_hi    = w_shift[SUM_W-1:DATA_W-1];
    assign w_fits  = (&w_hi) || !(|w_hi);
    assign w_clip  = w_shift[SUM_W-1] ? {1'b1, {(DATA_W - 1){1'b0}}}
                                      : {1'b0, {(DATA_W - 1){1'b1}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            o_out_row       <= r_sum_tag.row;
            o_out_col       <= r_sum_tag.col;
            o_product_value <= w_fits ? w_shift[DATA_W-1:0] : w_clip;
            o_saturated     <= !w_fits;
            o_size_error    <= r_sum_tag.err;
            o_last          <= r_sum_tag.last;
        end
    end

    assign o_out_valid = r_out_vld;

`ifndef ASSERT_OFF
    a_no_pop_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CALC) |-> !w_pop)
        else $error("command taken from the queue during a compute walk");

    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sum_vld && r_sum_tag.err) |-> r_sum_tag.last)
        else $error("size error word not marked last");

    a_counters_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CALC && !r_err) |->
            ({1'b0, r_k} < i_dims.ac) && ({1'b0, r_i} < i_dims.ar)
            && ({1'b0, r_j} < i_dims.bc))
        else $error("loop counter beyond matrix size");

    a_sum_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sum_vld && !w_out_load) |=> (r_sum_vld && $stable(r_sum)))
        else $error("finished sum lost before reaching the output register");
`endif

endmodule

// ----- sv/matrix_multiply_engine_unit.sv -----
// ----------------------------------------------------------------------------
// Matrix multiply engine
// Q16.16 matrix product engine with element writes, compute and size check.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                 Word
//  in       input      i_in_valid / o_in_stall   operation, row, column, value
//  out      output     o_out_valid / i_out_stall row, column, product, flags
//  cfg      input      i_cfg_valid / o_cfg_ready register index, data
//
//  An element write passes a four-word command queue and is stored once dequeued.
//  A compute runs a_rows * b_cols * a_cols terms (one on a size error), one per
//  cycle unless the output stalls; its last word passes the read, product, sum and
//  output registers. Reset is synchronous and clears the queue and pipeline. An
//  output stall freezes the pipeline once a finished sum is waiting. The input
//  stalls while the command queue is full and in the first cycle after reset.
// ----------------------------------------------------------------------------
module matrix_multiply_engine_unit
    import mme_pkg::*;
#(
    parameter int MAX_DIM   = MAX_DIM_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [OP_W-1:0]          i_operation,
    input  logic [IDX_W-1:0]         i_elem_row,
    input  logic [IDX_W-1:0]         i_elem_col,
    input  logic signed [DATA_W-1:0] i_elem_value,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [IDX_W-1:0]         o_out_row,
    output logic [IDX_W-1:0]         o_out_col,
    output logic signed [DATA_W-1:0] o_product_value,
    output logic                     o_saturated,
    output logic                     o_size_error,
    output logic                     o_last,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CIDX_W-1:0]        i_cfg_index,
    input  logic [DIM_W-1:0]         i_cfg_data
);

    localparam int DIM_CAP = (MAX_DIM < 8) ? MAX_DIM : 8;

    logic [DIM_W-1:0] r_a_rows;
    logic [DIM_W-1:0] r_a_cols;
    logic [DIM_W-1:0] r_b_rows;
    logic [DIM_W-1:0] r_b_cols;
    logic [DIM_W-1:0] w_b_rows_eff;
    t_dims            w_dims;

    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;
    t_cmd w_push_cmd;
    t_cmd w_head_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_rows <= DIM_W'(1);
            r_a_cols <= DIM_W'(1);
            r_b_rows <= DIM_W'(1);
            r_b_cols <= DIM_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_A_ROWS: r_a_rows <= i_cfg_data;
                REG_A_COLS: r_a_cols <= i_cfg_data;
                REG_B_ROWS: r_b_rows <= i_cfg_data;
                REG_B_COLS: r_b_cols <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_dims.ar       = eff_dim(r_a_rows, DIM_W'(DIM_CAP));
    assign w_dims.ac       = eff_dim(r_a_cols, DIM_W'(DIM_CAP));
    assign w_b_rows_eff    = eff_dim(r_b_rows, DIM_W'(DIM_CAP));
    assign w_dims.bc       = eff_dim(r_b_cols, DIM_W'(DIM_CAP));
    assign w_dims.mismatch = (w_dims.ac != w_b_rows_eff);

    mme_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_elem_row   (i_elem_row),
        .i_elem_col   (i_elem_col),
        .i_elem_value (i_elem_value),
        .i_fifo_full  (w_full),
        .o_push       (w_push),
        .o_cmd        (w_push_cmd)
    );

    mme_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    mme_back #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_dims          (w_dims),
        .i_cmd           (w_head_cmd),
        .i_empty         (w_empty),
        .o_pop           (w_pop),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_out_row       (o_out_row),
        .o_out_col       (o_out_col),
        .o_product_value (o_product_value),
        .o_saturated     (o_saturated),
        .o_size_error    (o_size_error),
        .o_last          (o_last)
    );

endmodule
